@@ rtl/core/sdc_pkg.sv @@
// shared constants, types and the stick-to-channel map of the stick deadband calibrator
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

   // fixed field widths
   localparam int STICK_COUNT = 4;
   localparam int STICK_W     = 2;
   localparam int RAW_W       = 12;
   localparam int TRIM_W      = 8;
   localparam int CHAN_W      = 2;
   localparam int POS_W       = 16;
   localparam int TRIM_OFF_W  = 12;
   localparam int SPAN_W      = 12;
   localparam int CAL_W       = 3 * SPAN_W;
   localparam int DB_W        = 8;
   localparam int MODE_W      = 2;
   localparam int STEP_W      = 4;

   // adc word width and the part of the raw field that is used
   localparam int SAMPLE_BITS  = 12;
   localparam int RAW_EFF_BITS = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;

   // parameter defaults
   localparam int OUT_TRAVEL_DEF = 1024;
   localparam int ADC_MID_DEF    = 2048;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CAL_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 3'd6;

   // reset values: low span 2048, centre 2048, high span 0
   localparam logic [CAL_W-1:0]  CAL_RESET  = 36'h000800800;
   localparam logic [DB_W-1:0]   DB_RESET   = 8'd0;
   localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
   localparam logic [STEP_W-1:0] STEP_RESET = 4'd1;

   // per-item side info carried down the pipeline
   typedef struct packed {
      logic [CHAN_W-1:0]            chan;
      logic signed [TRIM_OFF_W-1:0] trim_offset;
      logic                         neg;
      logic                         bad;
      logic [SPAN_W-1:0]            divisor;
   } sdc_side_type;

   // one result beat
   typedef struct packed {
      logic [CHAN_W-1:0]            chan;
      logic signed [POS_W-1:0]      position;
      logic signed [TRIM_OFF_W-1:0] trim_offset;
      logic                         bad;
   } sdc_rsp_type;

   // stick mode map: row is the mode, column the stick
   function automatic logic [CHAN_W-1:0] chan_map(input logic [MODE_W-1:0] mode,
                                                  input logic [STICK_W-1:0] stick);
      logic [CHAN_W-1:0] ch;
      begin
         ch = stick;
         case (mode)
            2'd0: ch = stick;
            2'd1: begin
               case (stick)
                  2'd1:    ch = 2'd2;
                  2'd2:    ch = 2'd1;
                  default: ch = stick;
               endcase
            end
            2'd2: begin
               case (stick)
                  2'd0:    ch = 2'd3;
                  2'd3:    ch = 2'd0;
                  default: ch = stick;
               endcase
            end
            default: ch = 2'd3 - stick;
         endcase
         return ch;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/stick_deadband_calibrate_top.sv @@
// stick deadband calibrator: mirror, centre, deadband, scale, pipelined divide, saturate, map
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_valid/req_stall  | stick_index, raw_sample, trim_count
//  rsp     | out       | rsp_valid/rsp_stall  | channel, position, trim_offset, bad_calib.
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata (ready always high)
//
//  one beat enters per cycle while req_stall is low; a taken request beat passes four
//  front stages, the restoring divider that retires one quotient bit per stage, and the
//  output register, which raises rsp_valid
//  reset is synchronous and clears valid bits and csr registers, not the data path
//  req_stall comes straight from the skid register: when rsp is stalled the pipeline runs
//  on until both the output register and the skid hold a beat, then freezes as a whole

module stick_deadband_calibrate_top #(
   parameter int OUT_TRAVEL = sdc_pkg::OUT_TRAVEL_DEF,
   parameter int ADC_MID    = sdc_pkg::ADC_MID_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [sdc_pkg::STICK_W-1:0]           req_stick_index,
   input  wire logic [sdc_pkg::RAW_W-1:0]             req_raw_sample,
   input  wire logic signed [sdc_pkg::TRIM_W-1:0]     req_trim_count,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [sdc_pkg::CHAN_W-1:0]                 rsp_channel,
   output logic signed [sdc_pkg::POS_W-1:0]           rsp_position,
   output logic signed [sdc_pkg::TRIM_OFF_W-1:0]      rsp_trim_offset,
   output logic                                       rsp_bad_calibration,
   // csr write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [sdc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [sdc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import sdc_pkg::*;

   // largest value a (possibly mirrored) sample or centre can take
   localparam int VAL_MAX  = (2 * ADC_MID > 4095) ? 2 * ADC_MID : 4095;
   localparam int VAL_BITS = $clog2(VAL_MAX + 1);
   // scaled magnitude, i.e. the dividend
   localparam int NUM_BITS = $clog2(VAL_MAX * OUT_TRAVEL + 1);
   localparam int DIV_W    = SPAN_W;

   localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((1 << RAW_EFF_BITS) - 1);

   // ------------------------------------------------------------------
   // csr registers
   // ------------------------------------------------------------------
   logic [CAL_W-1:0]  cal_ff [STICK_COUNT];
   logic [DB_W-1:0]   deadband_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [STEP_W-1:0] step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STICK_COUNT; i++) begin
            cal_ff[i] <= CAL_RESET;
         end
         deadband_ff <= DB_RESET;
         mode_ff     <= MODE_RESET;
         step_ff     <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_CAL0, CSR_CAL1, CSR_CAL2, CSR_CAL3: cal_ff[csr_index[STICK_W-1:0]] <= csr_wdata;
            CSR_DEADBAND: deadband_ff <= csr_wdata[DB_W-1:0];
            CSR_MODE:     mode_ff     <= csr_wdata[MODE_W-1:0];
            CSR_STEP:     step_ff     <= csr_wdata[STEP_W-1:0];
            default: ;  // writes past the last register are dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // flow control: everything moves while the skid slot is free
   // ------------------------------------------------------------------
   logic advance;
   logic skid_valid_ff;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ------------------------------------------------------------------
   // stage a: pick calibration, mirror stick 3, map channel, trim product
   // ------------------------------------------------------------------
   logic                         a_valid_ff;
   logic [VAL_BITS-1:0]          a_samp_ff, a_samp_in;
   logic [CAL_W-1:0]             a_cal_ff;
   sdc_side_type                 a_side_ff, a_side_in;

   logic [RAW_W-1:0]             raw_eff;
   logic signed [VAL_BITS:0]     mirror;
   logic signed [TRIM_OFF_W-1:0] trim_prod;

   always_comb begin
      raw_eff = req_raw_sample & RAW_MASK;
      mirror  = (VAL_BITS + 1)'(2 * ADC_MID) - (VAL_BITS + 1)'(raw_eff);
      if (req_stick_index == STICK_W'(STICK_COUNT - 1)) begin
         // mirrored stick, clamped at zero
         a_samp_in = mirror[VAL_BITS] ? '0 : mirror[VAL_BITS-1:0];
      end else begin
         a_samp_in = VAL_BITS'(raw_eff);
      end
      trim_prod = TRIM_OFF_W'(req_trim_count) * TRIM_OFF_W'($signed({1'b0, step_ff}));
      a_side_in             = '0;
      a_side_in.chan        = chan_map(mode_ff, req_stick_index);
      a_side_in.trim_offset = trim_prod;
   end

   // ------------------------------------------------------------------
   // stage b: offset from centre, both candidate divisors
   // ------------------------------------------------------------------
   logic                      b_valid_ff;
   logic signed [VAL_BITS:0]  b_off_ff, b_off_in;
   logic signed [SPAN_W:0]    b_div_hi_ff, b_div_hi_in;
   logic signed [SPAN_W:0]    b_div_lo_ff, b_div_lo_in;
   sdc_side_type              b_side_ff;

   always_comb begin
      b_off_in    = (VAL_BITS + 1)'(a_samp_ff) - (VAL_BITS + 1)'(a_cal_ff[2*SPAN_W-1:SPAN_W]);
      b_div_hi_in = (SPAN_W + 1)'(a_cal_ff[3*SPAN_W-1:2*SPAN_W]) - (SPAN_W + 1)'(deadband_ff);
      b_div_lo_in = (SPAN_W + 1)'(a_cal_ff[SPAN_W-1:0]) - (SPAN_W + 1)'(deadband_ff);
   end

   // ------------------------------------------------------------------
   // stage c: magnitude, deadband, divisor select, bad divisor flag
   // ------------------------------------------------------------------
   logic                   c_valid_ff;
   logic [VAL_BITS-1:0]    c_mag_ff, c_mag_in;
   sdc_side_type           c_side_ff, c_side_in;

   logic                   off_neg;
   logic [VAL_BITS-1:0]    off_mag;
   logic signed [SPAN_W:0] div_sel;
   logic                   is_positive;

   always_comb begin
      off_neg  = b_off_ff[VAL_BITS];
      off_mag  = VAL_BITS'(off_neg ? -b_off_ff : b_off_ff);
      c_mag_in = (off_mag > VAL_BITS'(deadband_ff)) ? off_mag - VAL_BITS'(deadband_ff) : '0;
      is_positive = !off_neg && (c_mag_in != '0);
      // zero after deadband divides by the low span
      div_sel = is_positive ? b_div_hi_ff : b_div_lo_ff;
      c_side_in         = b_side_ff;
      c_side_in.neg     = off_neg;
      c_side_in.bad     = div_sel[SPAN_W] || (div_sel == '0);
      c_side_in.divisor = div_sel[SPAN_W-1:0];
   end

   // ------------------------------------------------------------------
   // stage d: scale by the output travel
   // ------------------------------------------------------------------
   logic                d_valid_ff;
   logic [NUM_BITS-1:0] d_num_ff, d_num_in;
   sdc_side_type        d_side_ff;

   assign d_num_in = NUM_BITS'(c_mag_ff * OUT_TRAVEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_samp_ff   <= a_samp_in;
         a_cal_ff    <= cal_ff[req_stick_index];
         a_side_ff   <= a_side_in;
         b_off_ff    <= b_off_in;
         b_div_hi_ff <= b_div_hi_in;
         b_div_lo_ff <= b_div_lo_in;
         b_side_ff   <= a_side_ff;
         c_mag_ff    <= c_mag_in;
         c_side_ff   <= c_side_in;
         d_num_ff    <= d_num_in;
         d_side_ff   <= c_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // restoring divider, one quotient bit per stage; the dividend shifts
   // out at the top while quotient bits shift in at the bottom
   // ------------------------------------------------------------------
   logic                dv_valid_ff [NUM_BITS];
   logic [DIV_W-1:0]    dv_rem_ff   [NUM_BITS];
   logic [NUM_BITS-1:0] dv_num_ff   [NUM_BITS];
   sdc_side_type        dv_side_ff  [NUM_BITS];

   logic                dv_valid_in [NUM_BITS];
   logic [DIV_W-1:0]    dv_rem_in   [NUM_BITS];
   logic [NUM_BITS-1:0] dv_num_in   [NUM_BITS];
   sdc_side_type        dv_side_in  [NUM_BITS];

   always_comb begin
      logic                prev_valid;
      logic [DIV_W-1:0]    prev_rem;
      logic [NUM_BITS-1:0] prev_num;
      sdc_side_type        prev_side;
      logic [DIV_W:0]      trial;
      logic                q_bit;
      for (int k = 0; k < NUM_BITS; k++) begin
         if (k == 0) begin
            prev_valid = d_valid_ff;
            prev_rem   = '0;
            prev_num   = d_num_ff;
            prev_side  = d_side_ff;
         end else begin
            prev_valid = dv_valid_ff[k-1];
            prev_rem   = dv_rem_ff[k-1];
            prev_num   = dv_num_ff[k-1];
            prev_side  = dv_side_ff[k-1];
         end
         trial = {prev_rem, prev_num[NUM_BITS-1]};
         q_bit = (trial >= {1'b0, prev_side.divisor});
         dv_valid_in[k] = prev_valid;
         dv_rem_in[k]   = q_bit ? DIV_W'(trial - {1'b0, prev_side.divisor})
                                : trial[DIV_W-1:0];
         dv_num_in[k]   = {prev_num[NUM_BITS-2:0], q_bit};
         dv_side_in[k]  = prev_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            dv_valid_ff[k] <= dv_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_num_ff[k]  <= dv_num_in[k];
            dv_side_ff[k] <= dv_side_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // sign, saturation and bad divisor override
   // ------------------------------------------------------------------
   sdc_rsp_type         result;
   logic [NUM_BITS-1:0] quot;
   sdc_side_type        last_side;

   always_comb begin
      quot      = dv_num_ff[NUM_BITS-1];
      last_side = dv_side_ff[NUM_BITS-1];
      result.chan        = last_side.chan;
      result.trim_offset = last_side.trim_offset;
      result.bad         = last_side.bad;
      if (last_side.bad) begin
         result.position = '0;
      end else if (last_side.neg) begin
         // quotients above 32768 saturate; otherwise the magnitude is at most 32768, so the cut keeps the value
         result.position = (quot > 32768) ? -(POS_W'(32768)) : POS_W'(0) - POS_W'(quot);
      end else begin
         result.position = (quot > 32767) ? POS_W'(32767) : POS_W'(quot);
      end
   end

   // ------------------------------------------------------------------
   // output register and skid slot
   // ------------------------------------------------------------------
   logic        rsp_valid_ff;
   sdc_rsp_type rsp_ff;
   sdc_rsp_type skid_ff;
   logic        last_valid;
   logic        rsp_free;

   assign last_valid = dv_valid_ff[NUM_BITS-1] && advance;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         // skid drains first; the pipeline is frozen while it holds a beat
         rsp_valid_ff  <= skid_valid_ff || last_valid;
         skid_valid_ff <= 1'b0;
      end else if (last_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : result;
      end else if (last_valid) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel         = rsp_ff.chan;
   assign rsp_position        = rsp_ff.position;
   assign rsp_trim_offset     = rsp_ff.trim_offset;
   assign rsp_bad_calibration = rsp_ff.bad;

endmodule

`default_nettype wire

@@ rtl/core/sdc_check.sv @@
// port-level checks of the stick deadband calibrator and their bind
`timescale 1ns / 1ps
`default_nettype none

module sdc_check (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [sdc_pkg::CHAN_W-1:0]         rsp_channel,
   input wire logic signed [sdc_pkg::POS_W-1:0]   rsp_position,
   input wire logic signed [sdc_pkg::TRIM_OFF_W-1:0] rsp_trim_offset,
   input wire logic                               rsp_bad_calibration
);

   import sdc_pkg::*;

   // a stalled response beat stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel) && $stable(rsp_position)
         && $stable(rsp_trim_offset) && $stable(rsp_bad_calibration))
      else $error("stalled response beat changed");

   // input backpressure only while a response waits
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // backpressure starts only after the response side stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall rose without a response stall");

   // bad divisor forces a zero position
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_calibration |-> rsp_position == '0)
      else $error("bad calibration with nonzero position");

endmodule

bind stick_deadband_calibrate_top sdc_check u_sdc_check (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_channel         (rsp_channel),
   .rsp_position        (rsp_position),
   .rsp_trim_offset     (rsp_trim_offset),
   .rsp_bad_calibration (rsp_bad_calibration)
);

`default_nettype wire
